### design/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

### design/lruc_pkg.sv
// Types and codes for the LRU cache with expiry.
// No dependencies.
package lruc_pkg;
    localparam int KIND_W  = 2;
    localparam int LIFE_W  = 16;
    localparam int TIME_W  = 32;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;

    localparam logic [KIND_W-1:0] KIND_GET  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_EXPIRED = 2'd1;
    localparam logic [1:0] EV_LRU     = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [LIFE_W-1:0] lifetime;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             expired_drop;
        logic [1:0]       evicted;
    } rsp_t;
endpackage

### design/lru_cache_with_expiry.sv
// Top level of the LRU cache with expiry: sequencer around one entry RAM.
// Depends on lruc_pkg and lruc_ram.
//
// One item at a time: busy rises the cycle after start is accepted. A get or
// put scans every slot, then runs a rank-update pass over every slot, the
// write state and the done state; the next item can be taken in the cycle
// after done. A get that misses skips the update pass and the write; a tick
// or an unused kind goes straight from idle to done. Both passes read the
// entry RAM one slot a cycle, as it has a single read port. The result is
// shown for one cycle with done; the receiver cannot stall it. Valid bits
// live in flip-flops, cleared at reset.
module lru_cache_with_expiry #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  lruc_pkg::req_t          req,
    output logic                    busy,
    output logic                    done,
    output lruc_pkg::rsp_t          rsp,
    input  logic                    cfg_we,
    input  logic [lruc_pkg::CAP_W-1:0] cfg_wdata
);
    import lruc_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = KEY_BITS + VALUE_BITS + TIME_W + IW;
    localparam logic [IW-1:0] LAST = IW'(MAX_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DEC, S_WRITE, S_DONE
    } state_t;

    // RAM word layout: key, value, expiry, rank
    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    lruc_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [TIME_W-1:0]     r_exp;
    logic [IW-1:0]         r_rank;
    assign r_key  = rdata[EW-1 -: KEY_BITS];
    assign r_val  = rdata[EW-1-KEY_BITS -: VALUE_BITS];
    assign r_exp  = rdata[IW +: TIME_W];
    assign r_rank = rdata[IW-1:0];

    state_t                state_reg;
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [CAP_W-1:0]      cap_reg;
    logic [TIME_W-1:0]     time_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [TIME_W-1:0]     exp_reg;
    logic [IW-1:0]         idx_reg;   // slot being read
    logic                  rd_ok_reg; // rdata is valid and belongs to slot ridx_reg
    logic [IW-1:0]         ridx_reg;  // slot of rdata
    logic                  last_reg;
    // scan results
    logic                  fnd_reg, fexp_reg, xv_reg, lv_reg, fe_reg;
    logic [IW-1:0]         fslot_reg, xslot_reg, lslot_reg, eslot_reg;
    logic [IW-1:0]         xrank_reg;
    logic [VALUE_BITS-1:0] fval_reg;
    logic [TIME_W-1:0]     fexpv_reg;
    logic [IW-1:0]         frank_reg;
    logic [CW-1:0]         cnt_reg;
    // drop/fill plan
    logic                  drop_reg;
    logic [IW-1:0]         dslot_reg, drank_reg, tslot_reg;
    logic                  fill_reg;
    rsp_t                  rsp_reg;

    logic [CW-1:0] eff_cap;
    logic          slot_live;
    logic [TIME_W:0] exp_sum;

    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = CW'(1);
        else if (32'(cap_reg) > 32'(MAX_ENTRIES))
            eff_cap = CW'(MAX_ENTRIES);
        else
            eff_cap = CW'(cap_reg);
    end

    assign slot_live = valid_reg[ridx_reg];
    assign exp_sum   = {1'b0, time_reg} + {{(TIME_W+1-LIFE_W){1'b0}}, req.lifetime};

    // RAM address and write port
    always_comb
    begin
        raddr = idx_reg;
        we    = 1'b0;
        waddr = ridx_reg;
        wdata = rdata;
        if (state_reg == S_DEC && drop_reg && rd_ok_reg && slot_live
            && ridx_reg != dslot_reg && r_rank > drank_reg)
        begin
            we    = 1'b1;
            wdata = {r_key, r_val, r_exp, r_rank - IW'(1)};
        end
        else if (state_reg == S_WRITE)
        begin
            we    = fill_reg;
            waddr = tslot_reg;
            wdata = {key_reg, val_reg, exp_reg,
                     IW'(cnt_reg - CW'(drop_reg))};
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            cap_reg   <= CAP_W'(16);
            time_reg  <= '0;
            rd_ok_reg <= 1'b0;
            idx_reg   <= '0;
            kind_reg  <= '0;
            key_reg   <= '0;
            val_reg   <= '0;
            exp_reg   <= '0;
            ridx_reg  <= '0;
            last_reg  <= 1'b0;
            fnd_reg   <= 1'b0;
            fexp_reg  <= 1'b0;
            xv_reg    <= 1'b0;
            lv_reg    <= 1'b0;
            fe_reg    <= 1'b0;
            fslot_reg <= '0;
            xslot_reg <= '0;
            xrank_reg <= '0;
            lslot_reg <= '0;
            eslot_reg <= '0;
            fval_reg  <= '0;
            fexpv_reg <= '0;
            frank_reg <= '0;
            cnt_reg   <= '0;
            drop_reg  <= 1'b0;
            dslot_reg <= '0;
            drank_reg <= '0;
            tslot_reg <= '0;
            fill_reg  <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg  <= req.kind;
                        key_reg   <= KEY_BITS'(req.key);
                        val_reg   <= VALUE_BITS'(req.value);
                        exp_reg   <= exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
                        idx_reg   <= '0;
                        rd_ok_reg <= 1'b0;
                        fnd_reg <= 1'b0; xv_reg <= 1'b0; lv_reg <= 1'b0;
                        fe_reg  <= 1'b0; cnt_reg <= '0; last_reg <= 1'b0;
                        rsp_reg <= '0;
                        if (req.kind == KIND_GET || req.kind == KIND_PUT)
                            state_reg <= S_SCAN;
                        else
                        begin
                            if (req.kind == KIND_TICK && time_reg != '1)
                                time_reg <= time_reg + TIME_W'(1);
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (last_reg && !rd_ok_reg)
                    begin
                        // scan finished: rewind and work out the plan
                        idx_reg   <= '0;
                        last_reg  <= 1'b0;
                        rd_ok_reg <= 1'b0;
                        if (kind_reg == KIND_GET)
                        begin
                            if (fnd_reg)
                            begin
                                drop_reg  <= 1'b1;
                                fill_reg  <= !fexp_reg;
                                dslot_reg <= fslot_reg;
                                drank_reg <= frank_reg;
                                tslot_reg <= fslot_reg;
                                if (fexp_reg)
                                    rsp_reg.expired_drop <= 1'b1;
                                else
                                begin
                                    val_reg  <= fval_reg; exp_reg <= fexpv_reg;
                                    rsp_reg.hit <= 1'b1;
                                    rsp_reg.read_value <= VAL_W'(fval_reg);
                                end
                                state_reg <= S_DEC;
                            end
                            else
                            begin
                                drop_reg  <= 1'b0;
                                fill_reg  <= 1'b0;
                                state_reg <= S_DONE;
                            end
                        end
                        else
                        begin
                            fill_reg  <= 1'b1;
                            state_reg <= S_DEC;
                            if (fnd_reg)
                            begin
                                drop_reg <= 1'b1; dslot_reg <= fslot_reg;
                                drank_reg <= frank_reg; tslot_reg <= fslot_reg;
                            end
                            else if (cnt_reg >= eff_cap)
                            begin
                                drop_reg <= 1'b1;
                                if (xv_reg)
                                begin
                                    dslot_reg <= xslot_reg; tslot_reg <= xslot_reg;
                                    drank_reg <= xrank_reg;
                                    rsp_reg.evicted <= EV_EXPIRED;
                                end
                                else
                                begin
                                    dslot_reg <= lv_reg ? lslot_reg : '0;
                                    tslot_reg <= lv_reg ? lslot_reg : '0;
                                    drank_reg <= '0;
                                    rsp_reg.evicted <= EV_LRU;
                                end
                            end
                            else
                            begin
                                drop_reg  <= 1'b0;
                                tslot_reg <= fe_reg ? eslot_reg : '0;
                            end
                        end
                    end
                    else
                    begin
                        // one slot a cycle: issue read idx, inspect previous
                        rd_ok_reg <= !last_reg;
                        ridx_reg  <= idx_reg;
                        if (idx_reg == LAST)
                            last_reg <= 1'b1;
                        else
                            idx_reg <= idx_reg + IW'(1);
                        if (rd_ok_reg)
                        begin
                            if (slot_live)
                            begin
                                cnt_reg <= cnt_reg + CW'(1);
                                if (!fnd_reg && r_key == key_reg)
                                begin
                                    fnd_reg <= 1'b1; fslot_reg <= ridx_reg;
                                    fval_reg <= r_val; fexpv_reg <= r_exp;
                                    frank_reg <= r_rank;
                                    fexp_reg <= (r_exp <= time_reg);
                                end
                                if (!xv_reg && r_exp <= time_reg)
                                begin
                                    xv_reg <= 1'b1; xslot_reg <= ridx_reg;
                                    xrank_reg <= r_rank;
                                end
                                if (!lv_reg && r_rank == '0)
                                begin
                                    lv_reg <= 1'b1; lslot_reg <= ridx_reg;
                                end
                            end
                            else if (!fe_reg)
                            begin
                                fe_reg <= 1'b1; eslot_reg <= ridx_reg;
                            end
                        end
                    end
                end
                S_DEC:
                begin
                    // pass 2: close the rank gap left by the dropped slot
                    rd_ok_reg <= !last_reg;
                    ridx_reg  <= idx_reg;
                    if (idx_reg == LAST)
                        last_reg <= 1'b1;
                    else
                        idx_reg <= idx_reg + IW'(1);
                    if (last_reg && !rd_ok_reg)
                    begin
                        if (drop_reg)
                            valid_reg[dslot_reg] <= 1'b0;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (fill_reg)
                        valid_reg[tslot_reg] <= 1'b1;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    idx_reg   <= '0;
                    rd_ok_reg <= 1'b0;
                    last_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign rsp  = rsp_reg;
endmodule

### design/lruc_ram.sv
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
module lruc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### design/lruc_checker.sv
// Port-level checker for lru_cache_with_expiry, with its bind.
// Depends on lruc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lruc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input lruc_pkg::rsp_t rsp
);
    import lruc_pkg::*;

    // a result needs an item in flight
    `CHK_IMPL(a_done_busy, clk, rst_n, done, busy)
    // accepted item makes block busy
    `CHK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    // strobe lasts one cycle and frees the block
    `CHK_NEXT(a_done_free, clk, rst_n, done, !busy && !done)
    // hit and expiry drop are exclusive
    `CHK_IMPL(a_excl, clk, rst_n, done, !(rsp.hit && rsp.expired_drop))
    // miss reports zero value
    `CHK_IMPL(a_zero, clk, rst_n, done && !rsp.hit, rsp.read_value == '0)
endmodule

bind lru_cache_with_expiry lruc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

### verif/tb.sv
// Self-checking bench for lru_cache_with_expiry: gets, puts and ticks with a
// scoreboard that predicts every result. Depends on lruc_pkg and the block.
module tb;
    import lruc_pkg::*;

    localparam int SLOTS     = 16;
    localparam int RAND_OPS  = 900;
    localparam int LIMIT_CYC = 400000;

    // Cache predictor and expected-result store
    class cache_scoreboard;
        bit          vld [SLOTS];
        logic [31:0] keys [SLOTS];
        logic [31:0] vals [SLOTS];
        logic [31:0] expiry [SLOTS];
        int unsigned rank [SLOTS];
        logic [31:0] now;
        logic [4:0]  cap;
        rsp_t        pending [$];
        int          errors;

        function void clear();
            foreach (vld[i]) vld[i] = 0;
            now = 0;
            cap = 16;
            errors = 0;
        endfunction

        function int unsigned fill();
            int unsigned n = 0;
            foreach (vld[i]) if (vld[i]) n++;
            return n;
        endfunction

        function void unlink(int s);
            vld[s] = 0;
            foreach (vld[i]) if (vld[i] && rank[i] > rank[s]) rank[i]--;
        endfunction

        function void link(int s, logic [31:0] k, logic [31:0] v, logic [31:0] e);
            int unsigned n;
            n = fill();
            vld[s] = 1; keys[s] = k; vals[s] = v; expiry[s] = e; rank[s] = n;
        endfunction

        function int lookup(logic [31:0] k);
            foreach (vld[i]) if (vld[i] && keys[i] == k) return i;
            return -1;
        endfunction

        // Note an accepted item: update the model and queue its result
        function void note_item(req_t r);
            rsp_t        o;
            int          s;
            int          victim;
            int unsigned lim;
            logic [32:0] sum;
            logic [31:0] e;
            logic [31:0] v;
            o = '0;
            if (r.kind == KIND_GET) begin
                s = lookup(r.key);
                if (s >= 0) begin
                    if (expiry[s] <= now) begin
                        unlink(s);
                        o.expired_drop = 1;
                    end
                    else begin
                        v = vals[s]; e = expiry[s];
                        unlink(s);
                        link(s, r.key, v, e);
                        o.hit = 1;
                        o.read_value = v;
                    end
                end
            end
            else if (r.kind == KIND_PUT) begin
                sum = {1'b0, now} + r.lifetime;
                e = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                lim = (cap == 0) ? 1 : (cap > SLOTS) ? SLOTS : cap;
                s = lookup(r.key);
                if (s >= 0) unlink(s);
                else if (fill() >= lim) begin
                    victim = -1;
                    foreach (vld[i]) if (victim < 0 && vld[i] && expiry[i] <= now) victim = i;
                    if (victim >= 0) o.evicted = EV_EXPIRED;
                    else begin
                        foreach (vld[i]) if (victim < 0 && vld[i] && rank[i] == 0) victim = i;
                        o.evicted = EV_LRU;
                    end
                    if (victim < 0) victim = 0;
                    unlink(victim);
                    s = victim;
                end
                else begin
                    foreach (vld[i]) if (s < 0 && !vld[i]) s = i;
                    if (s < 0) s = 0;
                end
                link(s, r.key, r.value, e);
            end
            else if (r.kind == KIND_TICK) begin
                if (now != 32'hFFFF_FFFF) now++;
            end
            pending.push_back(o);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        // Compare one result with the oldest expectation
        task check_result(rsp_t g);
            rsp_t w;
            if (pending.size() == 0) begin
                report("unexpected result", g.read_value, 32'd0);
                return;
            end
            w = pending.pop_front();
            if (g.hit !== w.hit) report("hit", 32'(g.hit), 32'(w.hit));
            if (g.read_value !== w.read_value) report("read_value", g.read_value, w.read_value);
            if (g.expired_drop !== w.expired_drop)
                report("expired_drop", 32'(g.expired_drop), 32'(w.expired_drop));
            if (g.evicted !== w.evicted) report("evicted", 32'(g.evicted), 32'(w.evicted));
        endtask
    endclass

    logic       clk = 0;
    logic       rst_n = 0;
    logic       start = 0;
    req_t       req = '0;
    logic       busy;
    logic       done;
    rsp_t       rsp;
    logic       cfg_we = 0;
    logic [4:0] cfg_wdata = '0;

    cache_scoreboard sb;
    int          cycles = 0;
    int          results = 0;
    logic [31:0] key_pool [8];

    lru_cache_with_expiry DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req), .busy(busy),
        .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // Results are checked at the edge that ends their cycle
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            sb.check_result(rsp);
            results <= results + 1;
        end
        if (cycles > LIMIT_CYC)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one item and hold it until accepted
    task automatic send_item(req_t r);
        start <= 1;
        req <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_item(r);
        start <= 0;
        // block is busy for at least the next cycle
        @(posedge clk);
    endtask

    task automatic send_op(logic [1:0] k, logic [31:0] key, logic [31:0] v, logic [15:0] life);
        req_t r;
        r.kind = k; r.key = key; r.value = v; r.lifetime = life;
        send_item(r);
    endtask

    // Let the block drain, then write capacity
    task automatic set_capacity(logic [4:0] c);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we <= 1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we <= 0;
        sb.cap = c;
    endtask

    // Mostly keys from a small pool so hits, expiry and eviction all happen
    task automatic random_ops(int n);
        req_t r;
        int   burst;
        int   pick;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                repeat ($urandom_range(0, 30)) @(posedge clk);
            end
            burst--;
            pick = $urandom_range(0, 99);
            r.kind = pick < 40 ? KIND_GET : pick < 80 ? KIND_PUT : pick < 97 ? KIND_TICK : 2'd3;
            r.key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
            r.value = $urandom;
            r.lifetime = 16'(($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 12));
            send_item(r);
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, expiry at once, replace, LRU and expired eviction
        set_capacity(5'd2);
        send_op(KIND_GET, 32'h0, 32'h0, 16'h0);
        send_op(KIND_PUT, 32'h0, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(KIND_PUT, 32'hFFFF_FFFF, 32'h0, 16'h0);
        send_op(KIND_GET, 32'hFFFF_FFFF, 32'h0, 16'h0);
        send_op(KIND_PUT, 32'h5, 32'h55, 16'd2);
        send_op(KIND_PUT, 32'h6, 32'h66, 16'd1);
        send_op(KIND_GET, 32'h0, 32'h0, 16'h0);
        send_op(KIND_PUT, 32'h5, 32'hA5, 16'd3);
        send_op(KIND_PUT, 32'h7, 32'h77, 16'd9);
        send_op(KIND_TICK, 32'h0, 32'h0, 16'h0);
        send_op(KIND_PUT, 32'h8, 32'h88, 16'd9);
        send_op(KIND_GET, 32'h5, 32'h0, 16'h0);
        send_op(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(KIND_TICK, 32'h0, 32'h0, 16'h0);
        send_op(KIND_TICK, 32'h0, 32'h0, 16'h0);
        send_op(KIND_GET, 32'h7, 32'h0, 16'h0);
        set_capacity(5'd0);
        send_op(KIND_PUT, 32'h9, 32'h99, 16'd5);
        set_capacity(5'd31);

        // Random phases over several capacities
        random_ops(250);
        set_capacity(5'd1);
        random_ops(150);
        set_capacity(5'd4);
        random_ops(250);
        set_capacity(5'd16);
        random_ops(250);

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("covered %0d results: get, put, tick and unused kind over capacities 0..31",
                 results);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### files.f
+incdir+design
design/lruc_pkg.sv
design/lruc_ram.sv
design/lru_cache_with_expiry.sv
design/lruc_checker.sv
verif/tb.sv
